>>> sv/m4i_pkg.sv
`timescale 1ns / 1ps

package m4i_pkg;

   // Element and operand widths.
   localparam int unsigned ELEM_W  = 32;
   localparam int unsigned OPND_W  = ELEM_W + 1;
   localparam int unsigned PROD_W  = 2 * OPND_W;
   localparam int unsigned CHUNK_W = 32;

   // Exact integer widths of the intermediate terms.
   localparam int unsigned MINOR_W = 66;
   localparam int unsigned COF_W   = 97;
   localparam int unsigned DET_W   = 130;
   localparam int unsigned BOP_W   = 128;

   // Matrix store indexing.
   localparam int unsigned IDX_W = 4;
   localparam logic [IDX_W-1:0] LAST_INDEX = 4'd15;

   // Element queue between the loader and the engine.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;

   // One element on its way from the loader to the engine.
   typedef struct packed {
      logic [ELEM_W-1:0] value;
      logic [IDX_W-1:0]  index;
      logic              last;
   } elem_item_type;

   // Control that travels with one multiply-accumulate operation.
   typedef struct packed {
      logic       to_minor;
      logic       clear;
      logic       negate;
      logic [1:0] shift;
   } mac_ctl_type;

   // Row or column of a 3x3 submatrix: the pos-th index of 0..3 with skip removed.
   function automatic logic [1:0] other_index(input logic [1:0] skip, input logic [1:0] pos);
      return (pos < skip) ? pos : pos + 2'd1;
   endfunction

endpackage

>>> sv/m4i_queue.sv
`timescale 1ns / 1ps

module m4i_queue
   import m4i_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  elem_item_type push_item,
   output logic          full,
   input  logic          pop,
   output elem_item_type pop_item,
   output logic          empty
);

   elem_item_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full     = (fill_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> sv/m4i_front.sv
`timescale 1ns / 1ps

module m4i_front
   import m4i_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [ELEM_W-1:0] req_element_value,
   output logic              req_full,
   output logic              q_push,
   output elem_item_type     q_item,
   input  logic              q_full
);

   logic [IDX_W-1:0] load_count_ff, load_count_in;

   // Each accepted item is tagged with its place in the matrix.
   assign req_full      = q_full;
   assign q_push        = req_push && !q_full;
   assign q_item.value  = req_element_value;
   assign q_item.index  = load_count_ff;
   assign q_item.last   = (load_count_ff == LAST_INDEX);
   assign load_count_in = q_push ? load_count_ff + 1'b1 : load_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else begin
         load_count_ff <= load_count_in;
      end
   end

endmodule

>>> sv/m4i_engine.sv
`timescale 1ns / 1ps

module m4i_engine
   import m4i_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
)(
   input  logic                     clock,
   input  logic                     reset,
   input  elem_item_type            q_item,
   input  logic                     q_empty,
   output logic                     q_pop,
   input  logic                     rsp_pop,
   output logic                     rsp_empty,
   output logic signed [ELEM_W-1:0] rsp_inverse_value,
   output logic                     rsp_singular,
   output logic                     rsp_saturated,
   output logic                     rsp_last_element
);

   localparam int unsigned NUM_W = COF_W + 2 * FRAC_BITS;
   localparam int unsigned ACC_W = (NUM_W > DET_W) ? NUM_W : DET_W;

   localparam logic [3:0] ST_LOAD   = 4'd0;
   localparam logic [3:0] ST_MINOR  = 4'd1;
   localparam logic [3:0] ST_MWAIT  = 4'd2;
   localparam logic [3:0] ST_TERM   = 4'd3;
   localparam logic [3:0] ST_CWAIT  = 4'd4;
   localparam logic [3:0] ST_DLOAD  = 4'd5;
   localparam logic [3:0] ST_DTERM  = 4'd6;
   localparam logic [3:0] ST_DWAIT  = 4'd7;
   localparam logic [3:0] ST_DSETUP = 4'd8;
   localparam logic [3:0] ST_DCHECK = 4'd9;
   localparam logic [3:0] ST_DIV    = 4'd10;
   localparam logic [3:0] ST_DOUT   = 4'd11;

   localparam logic [1:0] TERM_TOP = 2'd2;
   localparam logic [1:0] DET_TOP  = 2'd3;

   // Sequencer state.
   logic [3:0]       state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [1:0]       m_ff, m_in;
   logic [1:0]       op_ff, op_in;
   logic [4:0]       div_cnt_ff, div_cnt_in;

   // Storage.
   logic [ELEM_W-1:0]       store_mem [16];
   logic signed [COF_W-1:0] cof_ff [16];
   logic                    store_we, cof_we;
   logic [BOP_W-1:0]        bop_ff, bop_in;

   // Issue of one multiply-accumulate operation.
   logic              iss_valid, iss_b_store;
   mac_ctl_type       iss_ctl;
   logic [IDX_W-1:0]  iss_a_addr, iss_b_addr;
   logic [OPND_W-1:0] iss_chunk;
   logic [1:0]        chunk_top;
   logic [CHUNK_W-1:0] chunk_bits;

   // Multiply-accumulate pipeline.
   logic                      v1_ff, v2_ff;
   mac_ctl_type               ctl1_ff, ctl2_ff;
   logic signed [OPND_W-1:0]  a_opnd_ff, b_opnd_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [MINOR_W-1:0] minor_acc_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]          addend, term;
   logic                      drained;

   // Division datapath.
   logic             det_zero_ff, det_zero_in, det_neg_ff, det_neg_in;
   logic [ACC_W-1:0] dmag_ff, dmag_in, det_abs;
   logic             cof_neg_ff, cof_neg_in;
   logic [ACC_W-1:0] num_mag_ff, num_mag_in;
   logic [ACC_W-1:0] rem_ff, rem_in;
   logic [ACC_W:0]   rem2, rem_diff;
   logic             rem_ge, overflow;
   logic [31:0]      quo_ff, quo_in;
   logic             high_ff, high_in;
   logic signed [COF_W-1:0] cof_rd;
   logic [COF_W-1:0]        cof_abs;

   // Output register.
   logic                     out_valid_ff, out_valid_in, out_write;
   logic signed [ELEM_W-1:0] out_val_ff, out_val_in;
   logic                     out_sing_ff, out_sing_in, out_sat_ff, out_sat_in;
   logic                     out_last_ff;
   logic                     res_neg;

   // Submatrix indexing for cofactor (row, col) and its minor number m.
   logic [1:0] row, col, p_sel, q_sel, rs0, rs1, rs2, cs_p, cs_q, cs_m;

   assign row   = k_ff[1:0];
   assign col   = k_ff[3:2];
   assign p_sel = (m_ff == 2'd0) ? 2'd1 : 2'd0;
   assign q_sel = (m_ff == 2'd2) ? 2'd1 : 2'd2;
   assign rs0   = other_index(row, 2'd0);
   assign rs1   = other_index(row, 2'd1);
   assign rs2   = other_index(row, 2'd2);
   assign cs_p  = other_index(col, p_sel);
   assign cs_q  = other_index(col, q_sel);
   assign cs_m  = other_index(col, m_ff);

   // Operand chunks of the wide factor; only the top chunk carries the sign.
   assign chunk_top  = (state_ff == ST_DTERM) ? DET_TOP : TERM_TOP;
   assign chunk_bits = bop_ff[{op_ff, 5'd0} +: CHUNK_W];
   assign iss_chunk  = (op_ff == chunk_top) ? {chunk_bits[CHUNK_W-1], chunk_bits}
                                            : {1'b0, chunk_bits};

   assign drained = !v1_ff && !v2_ff;

   // Division helpers.
   assign cof_rd   = cof_ff[k_ff];
   assign cof_abs  = cof_rd[COF_W-1] ? COF_W'(-cof_rd) : COF_W'(cof_rd);
   assign det_abs  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign overflow = (num_mag_ff >> CHUNK_W) >= dmag_ff;
   assign rem2     = {rem_ff, quo_ff[31]};
   assign rem_ge   = rem2 >= {1'b0, dmag_ff};
   assign rem_diff = rem2 - {1'b0, dmag_ff};
   assign res_neg  = cof_neg_ff ^ det_neg_ff;

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      m_in        = m_ff;
      op_in       = op_ff;
      div_cnt_in  = div_cnt_ff;
      bop_in      = bop_ff;
      det_zero_in = det_zero_ff;
      det_neg_in  = det_neg_ff;
      dmag_in     = dmag_ff;
      cof_neg_in  = cof_neg_ff;
      num_mag_in  = num_mag_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      high_in     = high_ff;
      iss_valid   = 1'b0;
      iss_b_store = 1'b0;
      iss_ctl     = '0;
      iss_a_addr  = '0;
      iss_b_addr  = '0;
      q_pop       = 1'b0;
      store_we    = 1'b0;
      cof_we      = 1'b0;
      out_write   = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               store_we = 1'b1;
               if (q_item.last) begin
                  k_in     = '0;
                  m_in     = '0;
                  op_in    = '0;
                  state_in = ST_MINOR;
               end
            end
         end
         ST_MINOR: begin
            iss_valid        = 1'b1;
            iss_b_store      = 1'b1;
            iss_ctl.to_minor = 1'b1;
            if (op_ff == 2'd0) begin
               iss_a_addr    = {rs1, cs_p};
               iss_b_addr    = {rs2, cs_q};
               iss_ctl.clear = 1'b1;
               op_in         = 2'd1;
            end else begin
               iss_a_addr     = {rs1, cs_q};
               iss_b_addr     = {rs2, cs_p};
               iss_ctl.negate = 1'b1;
               op_in          = 2'd0;
               state_in       = ST_MWAIT;
            end
         end
         ST_MWAIT: begin
            if (drained) begin
               bop_in   = {{(BOP_W - MINOR_W){minor_acc_ff[MINOR_W-1]}}, minor_acc_ff};
               op_in    = 2'd0;
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            iss_valid      = 1'b1;
            iss_a_addr     = {rs0, cs_m};
            iss_ctl.clear  = (m_ff == 2'd0) && (op_ff == 2'd0);
            iss_ctl.negate = m_ff[0] ^ row[0] ^ col[0];
            iss_ctl.shift  = op_ff;
            if (op_ff == TERM_TOP) begin
               op_in = 2'd0;
               if (m_ff == 2'd2) begin
                  m_in     = 2'd0;
                  state_in = ST_CWAIT;
               end else begin
                  m_in     = m_ff + 2'd1;
                  state_in = ST_MINOR;
               end
            end else begin
               op_in = op_ff + 2'd1;
            end
         end
         ST_CWAIT: begin
            if (drained) begin
               cof_we = 1'b1;
               m_in   = 2'd0;
               op_in  = 2'd0;
               if (k_ff == LAST_INDEX) begin
                  k_in     = '0;
                  state_in = ST_DLOAD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_MINOR;
               end
            end
         end
         ST_DLOAD: begin
            bop_in   = {{(BOP_W - COF_W){cof_rd[COF_W-1]}}, cof_rd};
            op_in    = 2'd0;
            state_in = ST_DTERM;
         end
         ST_DTERM: begin
            iss_valid     = 1'b1;
            iss_a_addr    = {k_ff[1:0], 2'b00};
            iss_ctl.clear = (k_ff == '0) && (op_ff == 2'd0);
            iss_ctl.shift = op_ff;
            if (op_ff == DET_TOP) begin
               op_in = 2'd0;
               if (k_ff == 4'd3) begin
                  k_in     = '0;
                  state_in = ST_DWAIT;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_DLOAD;
               end
            end else begin
               op_in = op_ff + 2'd1;
            end
         end
         ST_DWAIT: begin
            if (drained) begin
               det_zero_in = (acc_ff == '0);
               det_neg_in  = acc_ff[ACC_W-1];
               dmag_in     = det_abs;
               state_in    = ST_DSETUP;
            end
         end
         ST_DSETUP: begin
            cof_neg_in = cof_rd[COF_W-1];
            num_mag_in = ACC_W'(cof_abs) << (2 * FRAC_BITS);
            state_in   = ST_DCHECK;
         end
         ST_DCHECK: begin
            high_in = 1'b0;
            if (det_zero_ff) begin
               state_in = ST_DOUT;
            end else if (overflow) begin
               high_in  = 1'b1;
               state_in = ST_DOUT;
            end else begin
               rem_in     = num_mag_ff >> CHUNK_W;
               quo_in     = num_mag_ff[31:0];
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in     = rem_ge ? rem_diff[ACC_W-1:0] : rem2[ACC_W-1:0];
            quo_in     = {quo_ff[30:0], rem_ge};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               state_in = ST_DOUT;
            end
         end
         ST_DOUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_write = 1'b1;
               if (k_ff == LAST_INDEX) begin
                  k_in     = '0;
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_DSETUP;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Result value with saturation to the 32-bit range.
   always_comb begin
      out_val_in  = '0;
      out_sing_in = det_zero_ff;
      out_sat_in  = 1'b0;
      if (det_zero_ff) begin
         out_val_in = '0;
      end else if (res_neg) begin
         if (high_ff || (quo_ff > 32'h8000_0000)) begin
            out_val_in = 32'sh8000_0000;
            out_sat_in = 1'b1;
         end else begin
            out_val_in = -$signed(quo_ff);
         end
      end else begin
         if (high_ff || quo_ff[31]) begin
            out_val_in = 32'sh7FFF_FFFF;
            out_sat_in = 1'b1;
         end else begin
            out_val_in = $signed(quo_ff);
         end
      end
   end

   assign out_valid_in = out_write ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);

   // Shifted and signed product for the accumulators.
   assign addend = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff} << {ctl2_ff.shift, 5'd0};
   assign term   = ctl2_ff.negate ? ACC_W'(-addend) : addend;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         k_ff         <= '0;
         m_ff         <= '0;
         op_ff        <= '0;
         div_cnt_ff   <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         m_ff         <= m_in;
         op_ff        <= op_in;
         div_cnt_ff   <= div_cnt_in;
         v1_ff        <= iss_valid;
         v2_ff        <= v1_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   // Matrix store: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[q_item.index] <= q_item.value;
      end
      a_opnd_ff <= {store_mem[iss_a_addr][ELEM_W-1], store_mem[iss_a_addr]};
      if (iss_b_store) begin
         b_opnd_ff <= {store_mem[iss_b_addr][ELEM_W-1], store_mem[iss_b_addr]};
      end else begin
         b_opnd_ff <= iss_chunk;
      end
   end

   // Shared multiplier and the two accumulators.
   always_ff @(posedge clock) begin
      ctl1_ff <= iss_ctl;
      ctl2_ff <= ctl1_ff;
      prod_ff <= a_opnd_ff * b_opnd_ff;
      if (v2_ff) begin
         if (ctl2_ff.to_minor) begin
            minor_acc_ff <= (ctl2_ff.clear ? MINOR_W'(0) : minor_acc_ff) + term[MINOR_W-1:0];
         end else begin
            acc_ff <= (ctl2_ff.clear ? ACC_W'(0) : acc_ff) + term;
         end
      end
   end

   // Cofactor store and division registers.
   always_ff @(posedge clock) begin
      if (cof_we) begin
         cof_ff[k_ff] <= acc_ff[COF_W-1:0];
      end
      bop_ff      <= bop_in;
      det_zero_ff <= det_zero_in;
      det_neg_ff  <= det_neg_in;
      dmag_ff     <= dmag_in;
      cof_neg_ff  <= cof_neg_in;
      num_mag_ff  <= num_mag_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      high_ff     <= high_in;
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (out_write) begin
         out_val_ff  <= out_val_in;
         out_sing_ff <= out_sing_in;
         out_sat_ff  <= out_sat_in;
         out_last_ff <= (k_ff == LAST_INDEX);
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_inverse_value = out_val_ff;
   assign rsp_singular      = out_sing_ff;
   assign rsp_saturated     = out_sat_ff;
   assign rsp_last_element  = out_last_ff;

endmodule

>>> sv/matrix4_inverse_unit.sv
`timescale 1ns / 1ps

// 4x4 matrix inverse by the adjugate method, fixed point with FRAC_BITS fraction bits.
// Input channel: one matrix element per item, row-major, pushed with req_push while
// req_full is low. Result channel: sixteen items in row-major order, taken with rsp_pop
// while rsp_empty is low; rsp_last_element marks the sixteenth, rsp_singular a zero
// determinant and rsp_saturated an element clipped to the 32-bit range.
// Elements enter a four-item queue at one per cycle while it has room; the engine
// drains it into the matrix store. After the sixteenth element the engine forms the
// sixteen cofactors on the shared 33x33 multiplier and the determinant, then divides
// once per result with a radix-2 divider. Elements of the next matrix are queued while
// the engine works; req_full rises once the queue holds four. A stalled receiver holds
// the finished result in the output register and the engine waits before writing the
// next one. Reset empties the queue, clears the element count and the output valid
// flag; the matrix store needs no clearing.
module matrix4_inverse_unit
   import m4i_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  logic signed [ELEM_W-1:0] req_element_value,
   output logic                     req_full,
   input  logic                     rsp_pop,
   output logic                     rsp_empty,
   output logic signed [ELEM_W-1:0] rsp_inverse_value,
   output logic                     rsp_singular,
   output logic                     rsp_saturated,
   output logic                     rsp_last_element
);

   logic          q_push, q_full, q_pop, q_empty;
   elem_item_type q_in_item, q_out_item;

   m4i_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_element_value (req_element_value),
      .req_full          (req_full),
      .q_push            (q_push),
      .q_item            (q_in_item),
      .q_full            (q_full)
   );

   m4i_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_out_item),
      .empty     (q_empty)
   );

   m4i_engine #(
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .q_item            (q_out_item),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_inverse_value (rsp_inverse_value),
      .rsp_singular      (rsp_singular),
      .rsp_saturated     (rsp_saturated),
      .rsp_last_element  (rsp_last_element)
   );

   // A singular matrix gives clean zero elements.
   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_singular) |-> (rsp_inverse_value == '0 && !rsp_saturated))
      else $error("singular result carries a value or a saturation flag");

   // A clipped element sits exactly at one end of the range.
   a_saturated_limit : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_saturated) |->
         (rsp_inverse_value == 32'sh7FFF_FFFF || rsp_inverse_value == 32'sh8000_0000))
      else $error("saturated result is not at a range limit");

   // The engine only takes elements that are queued.
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("engine took an element from an empty queue");

   // The loader never pushes into a full queue.
   a_push_room : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("loader pushed into a full queue");

endmodule
